@@ hw/rtl/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Width of the tick thresholds in the register file
  localparam int CFG_W = 16;

  // APB geometry: four 32-bit registers at byte addresses 0, 4, 8, 12
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  // Register indexes (byte address bits [3:2])
  typedef enum logic [1:0] {
    REG_DEBOUNCE     = 2'd0,
    REG_DOUBLE_WIN   = 2'd1,
    REG_LONG_PRESS   = 2'd2,
    REG_ACTIVE_LEVEL = 2'd3
  } reg_idx_t;

  // Reset values of the registers
  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd5;
  localparam logic [CFG_W-1:0] DOUBLE_WIN_RST = 16'd30;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd100;
  localparam logic             ACTIVE_LVL_RST = 1'b0;

  // Event codes
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  // Register file contents seen by the classifier
  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] double_window_ticks;
    logic [CFG_W-1:0] long_press_ticks;
    logic             active_level;
  } cfg_t;

  // One result item
  typedef struct packed {
    event_t event_code;
    logic   held;
  } res_t;

endpackage

@@ hw/rtl/bpc_in_if.sv @@
// ----------------------------------------------------------------------------
// bpc_in_if
// Input channel: one raw pin sample per item.
// ----------------------------------------------------------------------------
interface bpc_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

@@ hw/rtl/bpc_out_if.sv @@
// ----------------------------------------------------------------------------
// bpc_out_if
// Output channel: one event code and debounced level per item.
// ----------------------------------------------------------------------------
interface bpc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_code;
  logic       held;

  modport source (output valid, output event_code, output held, input ready);
  modport sink   (input valid, input event_code, input held, output ready);
endinterface

@@ hw/rtl/bpc_regs.sv @@
// ----------------------------------------------------------------------------
// bpc_regs
// APB register file: debounce, double window, long press, active level.
// ----------------------------------------------------------------------------
module bpc_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bpc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [bpc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bpc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output bpc_pkg::cfg_t                     cfg
);
  import bpc_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks      <= DEBOUNCE_RST;
      cfg.double_window_ticks <= DOUBLE_WIN_RST;
      cfg.long_press_ticks    <= LONG_PRESS_RST;
      cfg.active_level        <= ACTIVE_LVL_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_DEBOUNCE:     cfg.debounce_ticks      <= pwdata[CFG_W-1:0];
        REG_DOUBLE_WIN:   cfg.double_window_ticks <= pwdata[CFG_W-1:0];
        REG_LONG_PRESS:   cfg.long_press_ticks    <= pwdata[CFG_W-1:0];
        REG_ACTIVE_LEVEL: cfg.active_level        <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_DEBOUNCE:     prdata = APB_DATA_W'(cfg.debounce_ticks);
      REG_DOUBLE_WIN:   prdata = APB_DATA_W'(cfg.double_window_ticks);
      REG_LONG_PRESS:   prdata = APB_DATA_W'(cfg.long_press_ticks);
      REG_ACTIVE_LEVEL: prdata = APB_DATA_W'(cfg.active_level);
      default:          prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/bpc_core.sv @@
// ----------------------------------------------------------------------------
// bpc_core
// Debounce and press classification for one sample; holds the tick state.
// ----------------------------------------------------------------------------
module bpc_core #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic          pin_level,
  input  bpc_pkg::cfg_t cfg,
  output bpc_pkg::res_t res_next
);
  import bpc_pkg::*;

  // compare width covers both counters and thresholds
  localparam int CW = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

  logic                   last_raw, debounced, long_done, awaiting_second;
  logic [TIMER_WIDTH-1:0] stable_elapsed, press_elapsed, release_elapsed;

  logic                   last_raw_next, debounced_next, long_done_next;
  logic                   awaiting_second_next;
  logic [TIMER_WIDTH-1:0] stable_elapsed_next, press_elapsed_next, release_elapsed_next;
  logic                   raw;
  logic                   change_ok;
  event_t                 ev_next;

  // one tick of the classifier
  always_comb begin
    raw                  = (pin_level == cfg.active_level);
    last_raw_next        = last_raw;
    debounced_next       = debounced;
    long_done_next       = long_done;
    awaiting_second_next = awaiting_second;
    ev_next              = EV_NONE;

    // saturating advance
    stable_elapsed_next  = (&stable_elapsed) ? stable_elapsed
                                             : stable_elapsed + TIMER_WIDTH'(1);
    press_elapsed_next   = (&press_elapsed) ? press_elapsed
                                            : press_elapsed + TIMER_WIDTH'(1);
    release_elapsed_next = (&release_elapsed) ? release_elapsed
                                              : release_elapsed + TIMER_WIDTH'(1);

    // raw change restarts the stability count
    if (raw != last_raw) begin
      last_raw_next       = raw;
      stable_elapsed_next = '0;
    end

    // debounced level change
    change_ok = (CW'(stable_elapsed_next) >= CW'(cfg.debounce_ticks)) && (raw != debounced);
    if (change_ok) begin
      debounced_next = raw;
      if (raw) begin
        long_done_next     = 1'b0;
        press_elapsed_next = '0;
      end else if (!long_done) begin
        if (awaiting_second &&
            CW'(release_elapsed_next) <= CW'(cfg.double_window_ticks)) begin
          awaiting_second_next = 1'b0;
          ev_next              = EV_DOUBLE;
        end else begin
          awaiting_second_next = 1'b1;
          release_elapsed_next = '0;
        end
      end
    end

    // long press fires once while held
    if (debounced_next && !long_done_next &&
        CW'(press_elapsed_next) >= CW'(cfg.long_press_ticks)) begin
      long_done_next       = 1'b1;
      awaiting_second_next = 1'b0;
      ev_next              = EV_LONG;
    end

    // double window ran out: single click
    if (awaiting_second_next && !debounced_next &&
        CW'(release_elapsed_next) > CW'(cfg.double_window_ticks)) begin
      awaiting_second_next = 1'b0;
      ev_next              = EV_SINGLE;
    end

    res_next.event_code = ev_next;
    res_next.held       = debounced_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw        <= 1'b0;
      debounced       <= 1'b0;
      long_done       <= 1'b0;
      awaiting_second <= 1'b0;
      stable_elapsed  <= '0;
      press_elapsed   <= '0;
      release_elapsed <= '0;
    end else if (take) begin
      last_raw        <= last_raw_next;
      debounced       <= debounced_next;
      long_done       <= long_done_next;
      awaiting_second <= awaiting_second_next;
      stable_elapsed  <= stable_elapsed_next;
      press_elapsed   <= press_elapsed_next;
      release_elapsed <= release_elapsed_next;
    end
  end

  // clicks only come with the button released
  a_click_released: assert property (@(posedge clk) disable iff (rst)
    (take && (ev_next == EV_SINGLE || ev_next == EV_DOUBLE)) |-> !debounced_next)
    else $error("click event while held");

  // long press only while held, and it latches long_done
  a_long_held: assert property (@(posedge clk) disable iff (rst)
    (take && ev_next == EV_LONG) |=> (debounced && long_done))
    else $error("long press without held state");

  // an accepted press restarts the press timer
  a_press_restart: assert property (@(posedge clk) disable iff (rst)
    (take && change_ok && raw) |=> (press_elapsed == '0 && debounced))
    else $error("press timer not restarted");

  // waiting for a second release while held happens only before a long press
  a_await_released: assert property (@(posedge clk) disable iff (rst)
    (awaiting_second && debounced) |-> !long_done)
    else $error("awaiting second release after long press");

endmodule

@@ hw/rtl/button_press_classifier.sv @@
// ----------------------------------------------------------------------------
// button_press_classifier
// Debounces a raw button pin and reports single, double and long presses.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  in_ch     in    valid/ready    pin_level
//  out_ch    out   valid/ready    event_code[1:0], held
//  apb       in    psel/penable   debounce, double window, long press, level
//
//  One item per cycle while the output is not stalled; an accepted item goes
//  through the input register, then the classifier into the result register,
//  before its result leaves on out_ch.
//  Synchronous active-high reset clears the tick state and both stage valids.
//  A stalled output holds its result; the input register still takes an item
//  while the stage behind it can move, so stalls back up one stage at a time.
// ----------------------------------------------------------------------------
module button_press_classifier #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  bpc_in_if.sink                         in_ch,
  bpc_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bpc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bpc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bpc_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import bpc_pkg::*;

  cfg_t cfg;
  res_t res_next;
  res_t res;
  logic in_valid, in_pin;
  logic out_valid;
  logic take;

  bpc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stage handshake
  assign take        = in_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_valid || take;

  bpc_core #(.TIMER_WIDTH(TIMER_WIDTH)) u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .pin_level (in_pin),
    .cfg       (cfg),
    .res_next  (res_next)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_pin <= in_ch.pin_level;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.event_code = res.event_code;
  assign out_ch.held       = res.held;

endmodule

@@ sim/bpc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_checker
// Watches the pin and event channels and the register port of the button
// press classifier. Every accepted pin item is run through a local copy of the
// debounce and click logic. Every accepted event item is compared against the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module bpc_checker
  import bpc_pkg::*;
#(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  bpc_in_if                     in_ch,
  bpc_out_if                    out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    pending
);

  // Local copy of the registers and of the tick state
  cfg_t                   cfg;
  logic                   last_raw;
  logic                   debounced;
  logic                   long_done;
  logic                   awaiting_second;
  logic [TIMER_WIDTH-1:0] stable_cnt;
  logic [TIMER_WIDTH-1:0] press_cnt;
  logic [TIMER_WIDTH-1:0] release_cnt;

  // Predicted event items, oldest first
  res_t event_q[$];

  // Tick counters stop at all ones
  function automatic logic [TIMER_WIDTH-1:0] sat_inc(input logic [TIMER_WIDTH-1:0] v);
    return (&v) ? v : v + TIMER_WIDTH'(1);
  endfunction

  // One pin sample in, one event item out; advances the local state
  function automatic res_t classify_tick(input logic pin);
    event_t ev;
    logic   pressed;
    res_t   r;
    ev      = EV_NONE;
    pressed = (pin == cfg.active_level);

    stable_cnt  = sat_inc(stable_cnt);
    press_cnt   = sat_inc(press_cnt);
    release_cnt = sat_inc(release_cnt);

    if (pressed != last_raw) begin
      last_raw   = pressed;
      stable_cnt = '0;
    end

    // debounced edge
    if (32'(stable_cnt) >= 32'(cfg.debounce_ticks) && pressed != debounced) begin
      debounced = pressed;
      if (debounced) begin
        long_done = 1'b0;
        press_cnt = '0;
      end else if (!long_done) begin
        if (awaiting_second && 32'(release_cnt) <= 32'(cfg.double_window_ticks)) begin
          awaiting_second = 1'b0;
          ev              = EV_DOUBLE;
        end else begin
          awaiting_second = 1'b1;
          release_cnt     = '0;
        end
      end
    end

    // long press fires once per press
    if (debounced && !long_done && 32'(press_cnt) >= 32'(cfg.long_press_ticks)) begin
      long_done       = 1'b1;
      awaiting_second = 1'b0;
      ev              = EV_LONG;
    end

    // window ran out after a lone release
    if (awaiting_second && !debounced &&
        32'(release_cnt) > 32'(cfg.double_window_ticks)) begin
      awaiting_second = 1'b0;
      ev              = EV_SINGLE;
    end

    r.event_code = ev;
    r.held       = debounced;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      cfg.debounce_ticks      = DEBOUNCE_RST;
      cfg.double_window_ticks = DOUBLE_WIN_RST;
      cfg.long_press_ticks    = LONG_PRESS_RST;
      cfg.active_level        = ACTIVE_LVL_RST;
      last_raw        = 1'b0;
      debounced       = 1'b0;
      long_done       = 1'b0;
      awaiting_second = 1'b0;
      stable_cnt      = '0;
      press_cnt       = '0;
      release_cnt     = '0;
      event_q.delete();
      fail_count = 0;
    end else begin
      // compare the event item leaving the block
      if (out_ch.valid && out_ch.ready) begin
        if (event_q.size() == 0) begin
          $error("event item with no prediction waiting: event_code %0d held %0b",
                 out_ch.event_code, out_ch.held);
          fail_count++;
        end else begin
          want = event_q.pop_front();
          if (out_ch.event_code !== want.event_code) begin
            $error("event_code mismatch: expected %0d, actual %0d",
                   want.event_code, out_ch.event_code);
            fail_count++;
          end
          if (out_ch.held !== want.held) begin
            $error("held mismatch: expected %0b, actual %0b", want.held, out_ch.held);
            fail_count++;
          end
        end
      end

      // predict for the pin item entering the block
      if (in_ch.valid && in_ch.ready)
        event_q.push_back(classify_tick(in_ch.pin_level));

      // register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_DEBOUNCE:     cfg.debounce_ticks      = pwdata[CFG_W-1:0];
          REG_DOUBLE_WIN:   cfg.double_window_ticks = pwdata[CFG_W-1:0];
          REG_LONG_PRESS:   cfg.long_press_ticks    = pwdata[CFG_W-1:0];
          REG_ACTIVE_LEVEL: cfg.active_level        = pwdata[0];
          default: ;
        endcase
      end
    end
    pending = event_q.size();
  end

endmodule

@@ sim/button_press_classifier_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_classifier_tb
// Drives pin samples and register writes into the button press classifier.
// A short directed run covers power-up with the pin held, zero debounce, zero
// long press time and double/single clicks; random phases then play press and
// release sequences timed around the thresholds, mixed with bounce and noise,
// under several register settings. The checker does all the comparing.
// ----------------------------------------------------------------------------
module button_press_classifier_tb;
  import bpc_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    fail_count;
  int                    pending;

  bpc_in_if  in_ch ();
  bpc_out_if out_ch ();

  button_press_classifier #(.TIMER_WIDTH(16)) dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bpc_checker #(.TIMER_WIDTH(16)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Current register settings, used to time the press sequences
  int   deb_t;
  int   win_t;
  int   lng_t;
  logic act_lvl;
  bit   steady;      // no idling on either side while set
  int   sent;

  // Event side back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= steady || ($urandom_range(99, 0) >= 7);
    end
  end

  // One pin item; entered and left at a falling edge
  task automatic send_pin(input logic pin);
    while (!steady && $urandom_range(99, 0) < 7) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.pin_level <= pin;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_run(input logic pin, input int n);
    for (int i = 0; i < n; i++) send_pin(pin);
  endtask

  // Stop the pin stream and wait until every event item is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Setup and access cycle, then the bus goes idle
  task automatic reg_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input int d, input int w, input int l, input logic a);
    drain();
    reg_write(REG_DEBOUNCE, d);
    reg_write(REG_DOUBLE_WIN, w);
    reg_write(REG_LONG_PRESS, l);
    reg_write(REG_ACTIVE_LEVEL, {31'b0, a});
    deb_t   = d;
    win_t   = w;
    lng_t   = l;
    act_lvl = a;
  endtask

  // Length spread around a threshold; far thresholds get short lengths
  function automatic int near_len(input int thr);
    if (thr > 120) return $urandom_range(120, 1);
    return $urandom_range(thr + 4, (thr > 4) ? thr - 4 : 1);
  endfunction

  // Ticks for the debounce filter; a threshold above 40 gets 0 to 40 ticks instead
  function automatic int settle_len(input int d);
    return (d > 40) ? $urandom_range(40, 0) : d;
  endfunction

  // On one call in three, one to three random pin samples as glitches
  task automatic bounce();
    if ($urandom_range(2, 0) == 0) begin
      repeat ($urandom_range(3, 1)) send_pin(1'($urandom_range(1, 0)));
    end
  endtask

  // Press, hold, release and rest, timed around the current thresholds
  task automatic press_cycle();
    int hold;
    int gap;
    hold = settle_len(deb_t) + near_len(lng_t);
    gap  = settle_len(deb_t) + near_len(win_t);
    if ($urandom_range(3, 0) == 0) gap += $urandom_range(60, 1);
    bounce();
    send_run(act_lvl, hold);
    bounce();
    send_run(~act_lvl, gap);
  endtask

  task automatic random_phase(input int n_items);
    int stop_at;
    stop_at = sent + n_items;
    while (sent < stop_at) begin
      if ($urandom_range(9, 0) == 0) begin
        repeat ($urandom_range(6, 1)) send_pin(1'($urandom_range(1, 0)));
      end else begin
        press_cycle();
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.pin_level = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    deb_t           = DEBOUNCE_RST;
    win_t           = DOUBLE_WIN_RST;
    lng_t           = LONG_PRESS_RST;
    act_lvl         = ACTIVE_LVL_RST;
    steady          = 1'b0;
    sent            = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // pin already pressed (active low) at power up, then released
    send_run(1'b0, 7);
    send_run(1'b1, 6);

    // zero debounce and zero long press: long fires on the press tick,
    // and the release after it gives no click
    set_config(0, 0, 0, 1'b1);
    send_run(1'b1, 1);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 1);

    // quick double click, then a lone release whose window runs out
    set_config(0, 3, 65535, 1'b1);
    send_run(1'b1, 1);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 5);

    // random phases over a spread of settings
    set_config(2, 12, 25, 1'b1);
    random_phase(240);
    set_config(0, 0, 1, 1'b0);
    random_phase(240);
    steady = 1'b1;
    set_config(5, 30, 100, 1'b0);
    random_phase(260);
    steady = 1'b0;
    set_config(65535, 20, 10, 1'b1);
    random_phase(100);
    set_config(3, 65535, 65535, 1'b0);
    random_phase(240);
    set_config(1, 40, 60, 1'b1);
    random_phase(260);
    set_config(4, 8, 15, 1'b0);
    random_phase(260);

    drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
